>>> sv/jtsr_pkg.sv
// shared types, constants and helper functions for the json token stream reader
// no dependencies
package jtsr_pkg;

    localparam int MAX_DEPTH_DEF = 32;
    localparam int QDEPTH        = 4;

    // event kinds
    localparam logic [3:0] EV_DICT_OPEN  = 4'd0;
    localparam logic [3:0] EV_DICT_CLOSE = 4'd1;
    localparam logic [3:0] EV_ARR_OPEN   = 4'd2;
    localparam logic [3:0] EV_ARR_CLOSE  = 4'd3;
    localparam logic [3:0] EV_KEY_CHAR   = 4'd4;
    localparam logic [3:0] EV_KEY_END    = 4'd5;
    localparam logic [3:0] EV_STR_CHAR   = 4'd6;
    localparam logic [3:0] EV_STR_END    = 4'd7;
    localparam logic [3:0] EV_INTEGER    = 4'd8;
    localparam logic [3:0] EV_DECIMAL    = 4'd9;
    localparam logic [3:0] EV_BOOLEAN    = 4'd10;
    localparam logic [3:0] EV_END        = 4'd11;
    localparam logic [3:0] EV_ERROR      = 4'd12;

    // characters
    localparam logic [15:0] CH_NUL    = 16'h0000;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_QUOTE  = 16'h0022;
    localparam logic [15:0] CH_APOS   = 16'h0027;
    localparam logic [15:0] CH_PLUS   = 16'h002B;
    localparam logic [15:0] CH_COMMA  = 16'h002C;
    localparam logic [15:0] CH_MINUS  = 16'h002D;
    localparam logic [15:0] CH_DOT    = 16'h002E;
    localparam logic [15:0] CH_0      = 16'h0030;
    localparam logic [15:0] CH_9      = 16'h0039;
    localparam logic [15:0] CH_COLON  = 16'h003A;
    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_UA     = 16'h0041;
    localparam logic [15:0] CH_UF     = 16'h0046;
    localparam logic [15:0] CH_UT     = 16'h0054;
    localparam logic [15:0] CH_UZ     = 16'h005A;
    localparam logic [15:0] CH_LBRK   = 16'h005B;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_RBRK   = 16'h005D;
    localparam logic [15:0] CH_LA     = 16'h0061;
    localparam logic [15:0] CH_LE     = 16'h0065;
    localparam logic [15:0] CH_LF_    = 16'h0066;
    localparam logic [15:0] CH_LL     = 16'h006C;
    localparam logic [15:0] CH_LN     = 16'h006E;
    localparam logic [15:0] CH_LR     = 16'h0072;
    localparam logic [15:0] CH_LS     = 16'h0073;
    localparam logic [15:0] CH_LT     = 16'h0074;
    localparam logic [15:0] CH_LU     = 16'h0075;
    localparam logic [15:0] CH_LBRC   = 16'h007B;
    localparam logic [15:0] CH_RBRC   = 16'h007D;

    localparam logic [63:0] MAG_CAP   = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [4:0]  frac;
        logic [5:0]  depth;
    } event_t;

    // one accepted word's worth of events
    typedef struct packed {
        logic   two;
        event_t ev0;
        event_t ev1;
    } rec_t;

    typedef struct packed {
        logic done;
        logic push;
    } front_stat_t;

    function automatic logic is_ws(input logic [15:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [15:0] c);
        logic [15:0] t;
        t = 16'h0000;
        if (is_digit(c)) begin
            t = c - CH_0;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_LA && c <= CH_LF_) begin
            t = c - CH_LA + 16'd10;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + 16'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [15:0] bool_char(input logic is_false, input logic [2:0] pos);
        logic [15:0] r;
        r = CH_NUL;
        if (is_false) begin
            unique case (pos)
                3'd0: r = CH_LF_;
                3'd1: r = CH_LA;
                3'd2: r = CH_LL;
                3'd3: r = CH_LS;
                3'd4: r = CH_LE;
                default: r = CH_NUL;
            endcase
        end else begin
            unique case (pos)
                3'd0: r = CH_LT;
                3'd1: r = CH_LR;
                3'd2: r = CH_LU;
                3'd3: r = CH_LE;
                default: r = CH_NUL;
            endcase
        end
        return r;
    endfunction

endpackage

>>> sv/jtsr_front.sv
// front end: lexer state, scope stack and number accumulator, one word per cycle while in_fire is high
// depends on jtsr_pkg
module jtsr_front
    import jtsr_pkg::*;
#(
    parameter int MaxDepth = MAX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [15:0] code_unit,
    output logic        push,
    output rec_t        rec,
    output front_stat_t stat
);

    localparam int DepthW = $clog2(MaxDepth + 1);

    localparam logic [3:0] PH_TOKEN       = 4'd0;
    localparam logic [3:0] PH_COMMA       = 4'd1;
    localparam logic [3:0] PH_STRING      = 4'd2;
    localparam logic [3:0] PH_ESCAPE      = 4'd3;
    localparam logic [3:0] PH_HEX         = 4'd4;
    localparam logic [3:0] PH_NUMBER      = 4'd5;
    localparam logic [3:0] PH_BOOL        = 4'd6;
    localparam logic [3:0] PH_AFTER_VALUE = 4'd7;
    localparam logic [3:0] PH_AFTER_KEY   = 4'd8;
    localparam logic [3:0] PH_AFTER_COLON = 4'd9;
    localparam logic [3:0] PH_DONE        = 4'd10;

    logic [3:0]          phase_reg, phase_next;
    logic [DepthW-1:0]   scopes_reg, scopes_next;
    logic [MaxDepth-1:0] stack_reg, stack_next;
    logic                expk_reg, expk_next;
    logic                hadc_reg, hadc_next;
    logic [63:0]         mant_reg, mant_next;
    logic [2:0]          nflags_reg, nflags_next;
    logic [4:0]          frac_reg, frac_next;
    logic [15:0]         hex_reg, hex_next;
    logic [2:0]          mpos_reg, mpos_next;

    logic        go, tok, start, do_push, do_pop, do_fail, do_finish, pdict;
    logic        num_v, oth_v;
    logic [3:0]  num_kind, oth_kind;
    logic [63:0] num_val, oth_val;
    logic [5:0]  num_depth;
    logic [67:0] acc;
    logic [63:0] dig;
    logic [4:0]  hv;
    logic [15:0] lc, want, esc;
    logic [2:0]  blen, mp1;
    logic        top_dict;

    always_comb begin
        phase_next  = phase_reg;
        scopes_next = scopes_reg;
        stack_next  = stack_reg;
        expk_next   = expk_reg;
        hadc_next   = hadc_reg;
        mant_next   = mant_reg;
        nflags_next = nflags_reg;
        frac_next   = frac_reg;
        hex_next    = hex_reg;
        mpos_next   = mpos_reg;
        go = 1'b1; tok = 1'b0; start = 1'b0; do_push = 1'b0; do_pop = 1'b0;
        do_fail = 1'b0; do_finish = 1'b0; pdict = 1'b0;
        num_v = 1'b0; oth_v = 1'b0;
        num_kind = EV_INTEGER; oth_kind = EV_ERROR;
        num_val = 64'd0; oth_val = 64'd0;
        num_depth = 6'(scopes_reg);
        dig = 64'(code_unit - CH_0);
        acc = ({4'd0, mant_reg} << 3) + ({4'd0, mant_reg} << 1) + {4'd0, dig};
        hv = hex_val(code_unit);
        lc = (code_unit >= CH_UA && code_unit <= CH_UZ) ? code_unit + 16'd32 : code_unit;
        blen = nflags_reg[0] ? 3'd5 : 3'd4;
        want = bool_char(nflags_reg[0], mpos_reg);
        mp1 = mpos_reg + 3'd1;
        esc = CH_NUL;
        top_dict = (scopes_reg != '0) && stack_reg[0];

        if (phase_reg == PH_DONE) go = 1'b0;

        // number: either absorbs the word or closes and hands the word on
        if (go && phase_next == PH_NUMBER) begin
            if (code_unit == CH_DOT) begin
                if (nflags_reg[1]) nflags_next[2] = 1'b1;
                else nflags_next[1] = 1'b1;
                go = 1'b0;
            end else if (is_digit(code_unit)) begin
                if (!nflags_reg[2]) begin
                    mant_next = (acc > {4'd0, MAG_CAP}) ? MAG_CAP : acc[63:0];
                    if (nflags_reg[1] && frac_reg != 5'd31) frac_next = frac_reg + 5'd1;
                end
                go = 1'b0;
            end else begin
                num_v    = 1'b1;
                num_kind = nflags_reg[1] ? EV_DECIMAL : EV_INTEGER;
                if (nflags_reg[0]) num_val = (~mant_reg) + 64'd1;
                else num_val = (mant_reg >= MAG_CAP) ? MAG_CAP - 64'd1 : mant_reg;
                hadc_next  = 1'b1;
                phase_next = top_dict ? PH_TOKEN : PH_AFTER_VALUE;
            end
        end

        if (go && phase_next == PH_AFTER_VALUE) begin
            if (is_ws(code_unit)) go = 1'b0;
            else if (code_unit == CH_COLON) begin
                do_fail = 1'b1;
                go = 1'b0;
            end else phase_next = PH_TOKEN;
        end

        if (go) begin
            unique case (phase_next)
                PH_TOKEN: begin
                    if (hadc_next && scopes_reg == '0) do_finish = 1'b1;
                    else if (is_ws(code_unit)) begin end
                    else if (code_unit == CH_NUL) do_finish = 1'b1;
                    else if (code_unit == CH_COMMA) phase_next = PH_COMMA;
                    else tok = 1'b1;
                end
                PH_COMMA: begin
                    if (!is_ws(code_unit)) tok = 1'b1;
                end
                PH_STRING: begin
                    if (code_unit == CH_NUL) do_fail = 1'b1;
                    else if (code_unit == CH_BSLASH) phase_next = PH_ESCAPE;
                    else if (code_unit == CH_QUOTE) begin
                        oth_v = 1'b1;
                        if (expk_reg) begin
                            oth_kind   = EV_KEY_END;
                            expk_next  = 1'b0;
                            phase_next = PH_AFTER_KEY;
                        end else begin
                            oth_kind   = EV_STR_END;
                            hadc_next  = 1'b1;
                            phase_next = top_dict ? PH_TOKEN : PH_AFTER_VALUE;
                        end
                    end else begin
                        oth_v    = 1'b1;
                        oth_kind = expk_reg ? EV_KEY_CHAR : EV_STR_CHAR;
                        oth_val  = 64'(code_unit);
                    end
                end
                PH_ESCAPE: begin
                    if (code_unit == CH_LN) esc = CH_LF;
                    else if (code_unit == CH_LR) esc = CH_CR;
                    else if (code_unit == CH_LT) esc = CH_TAB;
                    else esc = code_unit;
                    if (code_unit == CH_LU) begin
                        hex_next   = 16'd0;
                        mpos_next  = 3'd0;
                        phase_next = PH_HEX;
                    end else if (code_unit == CH_LN || code_unit == CH_LR ||
                                 code_unit == CH_LT || code_unit == CH_BSLASH ||
                                 code_unit == CH_APOS || code_unit == CH_QUOTE) begin
                        oth_v      = 1'b1;
                        oth_kind   = expk_reg ? EV_KEY_CHAR : EV_STR_CHAR;
                        oth_val    = 64'(esc);
                        phase_next = PH_STRING;
                    end else do_fail = 1'b1;
                end
                PH_HEX: begin
                    if (!hv[4]) do_fail = 1'b1;
                    else begin
                        hex_next  = {hex_reg[11:0], hv[3:0]};
                        mpos_next = mp1;
                        if (mp1 >= 3'd4) begin
                            oth_v      = 1'b1;
                            oth_kind   = expk_reg ? EV_KEY_CHAR : EV_STR_CHAR;
                            oth_val    = 64'({hex_reg[11:0], hv[3:0]});
                            mpos_next  = 3'd0;
                            phase_next = PH_STRING;
                        end
                    end
                end
                PH_BOOL: begin
                    if (mpos_reg >= blen || lc != want) do_fail = 1'b1;
                    else begin
                        mpos_next = mp1;
                        if (mp1 == blen) begin
                            oth_v      = 1'b1;
                            oth_kind   = EV_BOOLEAN;
                            oth_val    = nflags_reg[0] ? 64'd0 : 64'd1;
                            mpos_next  = 3'd0;
                            hadc_next  = 1'b1;
                            phase_next = top_dict ? PH_TOKEN : PH_AFTER_VALUE;
                        end
                    end
                end
                PH_AFTER_KEY: begin
                    if (is_ws(code_unit)) begin end
                    else if (code_unit == CH_COLON) phase_next = PH_AFTER_COLON;
                    else do_fail = 1'b1;
                end
                PH_AFTER_COLON: begin
                    if (is_ws(code_unit)) begin end
                    else if (code_unit == CH_LBRC) begin do_push = 1'b1; pdict = 1'b1; end
                    else if (code_unit == CH_LBRK) do_push = 1'b1;
                    else start = 1'b1;
                end
                default: begin end
            endcase
        end

        if (tok) begin
            if (code_unit == CH_LBRC) begin do_push = 1'b1; pdict = 1'b1; end
            else if (code_unit == CH_LBRK) do_push = 1'b1;
            else if (code_unit == CH_RBRC) begin do_pop = 1'b1; pdict = 1'b1; end
            else if (code_unit == CH_RBRK) do_pop = 1'b1;
            else if (code_unit == CH_SEMI) do_finish = 1'b1;
            else if (top_dict) begin
                if (code_unit == CH_QUOTE) begin
                    expk_next  = 1'b1;
                    phase_next = PH_STRING;
                end else do_fail = 1'b1;
            end else start = 1'b1;
        end

        if (start) begin
            if (code_unit == CH_QUOTE) begin
                expk_next  = 1'b0;
                phase_next = PH_STRING;
            end else if (is_digit(code_unit) || code_unit == CH_PLUS ||
                         code_unit == CH_MINUS) begin
                mant_next   = is_digit(code_unit) ? dig : 64'd0;
                nflags_next = (code_unit == CH_MINUS) ? 3'b001 : 3'b000;
                frac_next   = 5'd0;
                phase_next  = PH_NUMBER;
            end else if (code_unit == CH_LT || code_unit == CH_UT ||
                         code_unit == CH_LF_ || code_unit == CH_UF) begin
                nflags_next = (code_unit == CH_LF_ || code_unit == CH_UF) ? 3'b001 : 3'b000;
                mpos_next   = 3'd1;
                phase_next  = PH_BOOL;
            end else do_fail = 1'b1;
        end

        if (do_push) begin
            if (scopes_reg >= DepthW'(MaxDepth)) do_fail = 1'b1;
            else begin
                stack_next  = MaxDepth'({stack_reg, pdict});
                scopes_next = scopes_reg + 1'b1;
                oth_v       = 1'b1;
                oth_kind    = pdict ? EV_DICT_OPEN : EV_ARR_OPEN;
                phase_next  = PH_TOKEN;
            end
        end

        if (do_pop) begin
            if (scopes_reg == '0 || stack_reg[0] != pdict) do_fail = 1'b1;
            else begin
                stack_next  = stack_reg >> 1;
                scopes_next = scopes_reg - 1'b1;
                oth_v       = 1'b1;
                oth_kind    = pdict ? EV_DICT_CLOSE : EV_ARR_CLOSE;
                phase_next  = PH_TOKEN;
            end
        end

        if (do_fail || do_finish) begin
            oth_v      = 1'b1;
            oth_kind   = do_fail ? EV_ERROR : EV_END;
            oth_val    = 64'd0;
            phase_next = PH_DONE;
        end
    end

    // pack events in emission order
    always_comb begin
        rec.two       = num_v && oth_v;
        rec.ev1.kind  = oth_kind;
        rec.ev1.value = oth_val;
        rec.ev1.frac  = 5'd0;
        rec.ev1.depth = 6'(scopes_next);
        if (num_v) begin
            rec.ev0.kind  = num_kind;
            rec.ev0.value = num_val;
            rec.ev0.frac  = (num_kind == EV_DECIMAL) ? frac_reg : 5'd0;
            rec.ev0.depth = num_depth;
        end else begin
            rec.ev0 = rec.ev1;
        end
    end

    assign push      = in_fire && (num_v || oth_v);
    assign stat.done = (phase_reg == PH_DONE);
    assign stat.push = push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TOKEN;
            scopes_reg <= '0;
            expk_reg   <= 1'b0;
            hadc_reg   <= 1'b0;
            nflags_reg <= 3'd0;
            frac_reg   <= 5'd0;
            mpos_reg   <= 3'd0;
            mant_reg   <= 64'd0;
            hex_reg    <= 16'd0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            scopes_reg <= scopes_next;
            expk_reg   <= expk_next;
            hadc_reg   <= hadc_next;
            nflags_reg <= nflags_next;
            frac_reg   <= frac_next;
            mpos_reg   <= mpos_next;
            mant_reg   <= mant_next;
            hex_reg    <= hex_next;
        end
    end

    // scope kinds shift line, top of stack at bit 0
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            stack_reg <= stack_next;
        end
    end

endmodule

>>> sv/jtsr_queue.sv
// short queue of per-word event records between front and back
// depends on jtsr_pkg
module jtsr_queue
    import jtsr_pkg::*;
#(
    parameter int Depth = QDEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  rec_t wr_rec,
    input  logic pop,
    output rec_t rd_rec,
    output logic not_empty,
    output logic full
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    rec_t          mem_reg [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(Depth));
    assign rd_rec    = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

>>> sv/jtsr_back.sv
// back end: walks each record's events into the output register
// depends on jtsr_pkg
module jtsr_back
    import jtsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  rec_t        q_rec,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  ev_kind,
    output logic [63:0] ev_value,
    output logic [4:0]  ev_frac,
    output logic [5:0]  ev_depth,
    output logic        ev_last
);

    logic   idx_reg;
    logic   valid_reg;
    logic   load, last;
    event_t ev;

    assign load  = q_valid && (!valid_reg || m_ready);
    assign last  = !q_rec.two || idx_reg;
    assign ev    = idx_reg ? q_rec.ev1 : q_rec.ev0;
    assign q_pop = load && last;
    assign m_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else begin
            if (load) valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
            if (load) idx_reg <= !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ev_kind  <= ev.kind;
            ev_value <= ev.value;
            ev_frac  <= ev.frac;
            ev_depth <= ev.depth;
            ev_last  <= last;
        end
    end

endmodule

>>> sv/json_token_stream_reader.sv
// top level of the json token stream reader: front lexer, record queue, output stage
// depends on jtsr_pkg, jtsr_front, jtsr_queue, jtsr_back
//
// Streaming JSON tokenizer. One UTF-16 code unit is taken per cycle on the s_ side
// while s_ready is high (0 marks end of content) and JSON events leave on the m_ side,
// one per cycle while m_ready is high. The lexer front end handles each accepted word
// and writes the events it causes (one or two) as one record into a 4-entry queue;
// s_ready is low only while that queue is full. With at most one event per word and
// m_ready high the block sustains one word per cycle. Each event is registered in the
// queue and then in the output register. After an end or error event the block keeps
// accepting words and discards them until reset. Scope nesting is limited to MaxDepth;
// opening beyond that yields an error event.
module json_token_stream_reader
    import jtsr_pkg::*;
#(
    parameter int MaxDepth = MAX_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_kind,
    output logic signed [63:0] m_event_value,
    output logic [4:0]  m_fraction_digits,
    output logic [5:0]  m_scope_depth,
    output logic        m_last_of_item
);

    // handshake between the sides
    logic        in_fire;
    logic        q_full, q_valid, q_pop, push;
    rec_t        wr_rec, rd_rec;
    front_stat_t fstat;
    logic [63:0] ev_value;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    // lexer, scope stack and number accumulator
    jtsr_front #(.MaxDepth(MaxDepth)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .code_unit (s_code_unit),
        .push      (push),
        .rec       (wr_rec),
        .stat      (fstat)
    );

    // decouples the lexer from output back pressure
    jtsr_queue #(.Depth(QDEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_rec    (wr_rec),
        .pop       (q_pop),
        .rd_rec    (rd_rec),
        .not_empty (q_valid),
        .full      (q_full)
    );

    // serializes records into single events
    jtsr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rec    (rd_rec),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .ev_kind  (m_event_kind),
        .ev_value (ev_value),
        .ev_frac  (m_fraction_digits),
        .ev_depth (m_scope_depth),
        .ev_last  (m_last_of_item)
    );

    assign m_event_value = ev_value;

`ifndef SYNTHESIS
    // the queue is never written while full
    assert property (@(posedge aclk) disable iff (!aresetn) fstat.push |-> !q_full)
        else $error("record queue overflow");

    // once finished the lexer stays finished
    assert property (@(posedge aclk) disable iff (!aresetn) fstat.done |=> fstat.done)
        else $error("lexer left the finished state");

    // nothing is produced after the terminal event
    assert property (@(posedge aclk) disable iff (!aresetn) fstat.done |-> !fstat.push)
        else $error("event produced after end or error");

    // end and error are always the final event of their word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == EV_END || m_event_kind == EV_ERROR) |-> m_last_of_item)
        else $error("terminal event not last of word");
`endif

endmodule
